>>> design/clps_pkg.sv
// Package: shared constants, opcodes, pin table and gamma table function for the LED scanner.
`default_nettype none

package clps_pkg;

    // Fixed geometry of the charlieplexed array
    localparam int LED_COUNT = 12;
    localparam int PIN_COUNT = 4;

    // Default tuning, overridable at the top level
    localparam int PWM_STEPS_DEF  = 64;
    localparam int GAMMA_X100_DEF = 220;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int LED_W    = 4;
    localparam int LEVEL_W  = 8;
    localparam int STATE_W  = 4;
    localparam int PIN_IDX_W = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_SET_ONE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_ALL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_OFF     = 2'd3;

    // Shown-state codes
    localparam logic [STATE_W-1:0] HIZ_STATE   = 4'd12;
    localparam logic [STATE_W-1:0] LAST_NONE   = 4'd13;
    localparam logic [PIN_COUNT-1:0] PIN_ALL   = 4'hF;

    // Fixed-point precision of the gamma computation
    localparam int FRAC_BITS = 24;

    // Anode pin of each LED
    function automatic logic [PIN_IDX_W-1:0] led_anode(input logic [STATE_W-1:0] led);
        logic [PIN_IDX_W-1:0] p;
        case (led)
            4'd0:    p = 2'd0;
            4'd1:    p = 2'd2;
            4'd2:    p = 2'd1;
            4'd3:    p = 2'd3;
            4'd4:    p = 2'd0;
            4'd5:    p = 2'd3;
            4'd6:    p = 2'd0;
            4'd7:    p = 2'd1;
            4'd8:    p = 2'd1;
            4'd9:    p = 2'd2;
            4'd10:   p = 2'd2;
            4'd11:   p = 2'd3;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    // Cathode pin of each LED
    function automatic logic [PIN_IDX_W-1:0] led_cathode(input logic [STATE_W-1:0] led);
        logic [PIN_IDX_W-1:0] p;
        case (led)
            4'd0:    p = 2'd2;
            4'd1:    p = 2'd0;
            4'd2:    p = 2'd3;
            4'd3:    p = 2'd1;
            4'd4:    p = 2'd3;
            4'd5:    p = 2'd0;
            4'd6:    p = 2'd1;
            4'd7:    p = 2'd0;
            4'd8:    p = 2'd2;
            4'd9:    p = 2'd1;
            4'd10:   p = 2'd3;
            4'd11:   p = 2'd2;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    // Integer square root, bit by bit (elaboration only)
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned bv;
        longint unsigned xv;
        int i;
        r  = 0;
        bv = 64'h1 << 62;
        xv = x;
        for (i = 0; i < 32; i++)
            if (bv > xv)
                bv = bv >> 2;
        for (i = 0; i < 32; i++) begin
            if (bv != 0) begin
                if (xv >= r + bv) begin
                    xv = xv - (r + bv);
                    r  = (r >> 1) + bv;
                end
                else begin
                    r = r >> 1;
                end
                bv = bv >> 2;
            end
        end
        return r;
    endfunction

    // log2 with FRAC_BITS fraction bits by repeated squaring (elaboration only)
    function automatic longint unsigned log2_fixed(input longint unsigned n);
        longint unsigned p;
        longint unsigned m;
        longint unsigned r;
        int i;
        int b;
        p = 0;
        for (i = 0; i < 30; i++)
            if ((n >> (p + 1)) != 0)
                p = p + 1;
        m = n << (30 - p);
        r = p << FRAC_BITS;
        for (b = FRAC_BITS - 1; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r = r | (64'd1 << b);
            end
        end
        return r;
    endfunction

    // Gamma-corrected duty for brightness b (elaboration only)
    function automatic int gamma_value(input int b, input int steps, input int gx100);
        longint unsigned roots [0:FRAC_BITS];
        longint e;
        longint t;
        longint unsigned u;
        longint unsigned f;
        longint unsigned v;
        longint unsigned total;
        longint unsigned res;
        int q;
        int s;
        int k;
        int d;
        d = steps - 1;
        if (b == 0 || d == 0)
            return 0;
        roots[0] = 64'd2 << 30;
        for (k = 1; k <= FRAC_BITS; k++)
            roots[k] = int_sqrt(roots[k-1] << 30);
        e = longint'(log2_fixed(longint'(b))) - longint'(log2_fixed(longint'(d)));
        t = e * longint'(gx100) / 64'sd100;
        u = longint'(t + (64'sd32 << FRAC_BITS));
        q = int'(u >> FRAC_BITS) - 32;
        f = u & ((64'd1 << FRAC_BITS) - 64'd1);
        v = 64'd1 << 30;
        for (k = 1; k <= FRAC_BITS; k++)
            if (((f >> (FRAC_BITS - k)) & 64'd1) != 0)
                v = (v * roots[k]) >> 30;
        total = longint'(steps) * v;
        s = 30 - q;
        if (s < 1)
            s = 1;
        if (s > 63)
            return 0;
        res = (total + (64'd1 << (s - 1))) >> s;
        if (res > longint'(steps))
            res = longint'(steps);
        return int'(res);
    endfunction

endpackage

`default_nettype wire

>>> design/clps_in_if.sv
// Interface: input item channel of the LED scanner.
`default_nettype none

interface clps_in_if
    import clps_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [LED_W-1:0]    led_number;
    logic [LEVEL_W-1:0]  level;

    modport source (output valid, output opcode, output led_number, output level,
                    input ready);
    modport sink   (input valid, input opcode, input led_number, input level,
                    output ready);
endinterface

`default_nettype wire

>>> design/clps_out_if.sv
// Interface: result item channel of the LED scanner.
`default_nettype none

interface clps_out_if
    import clps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATE_W-1:0]   shown_state;
    logic [PIN_COUNT-1:0] open_drain_mask;
    logic [PIN_COUNT-1:0] pin_level_mask;
    logic                 changed;

    modport source (output valid, output shown_state, output open_drain_mask,
                    output pin_level_mask, output changed, input ready);
    modport sink   (input valid, input shown_state, input open_drain_mask,
                    input pin_level_mask, input changed, output ready);
endinterface

`default_nettype wire

>>> design/clps_cfg_if.sv
// Interface: configuration write channel carrying the gamma enable bit.
`default_nettype none

interface clps_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/clps_gamma_rom.sv
// Gamma lookup table built at elaboration and read combinationally.
`default_nettype none

module clps_gamma_rom
    import clps_pkg::*;
#(
    parameter int PWM_STEPS  = PWM_STEPS_DEF,
    parameter int GAMMA_X100 = GAMMA_X100_DEF,
    parameter int DUTY_W     = $clog2(PWM_STEPS + 1)
)
(
    input  wire logic [DUTY_W-1:0] brightness,
    output logic      [DUTY_W-1:0] duty
);

    logic [DUTY_W-1:0] rom [0:PWM_STEPS];

    // Fill the table with constant values
    for (genvar g = 0; g <= PWM_STEPS; g++) begin : g_rom
        assign rom[g] = DUTY_W'(gamma_value(g, PWM_STEPS, GAMMA_X100));
    end

    // Look up; brightness is already clamped to the table depth
    assign duty = rom[brightness];

endmodule

`default_nettype wire

>>> design/charlieplex_led_pwm_scanner.sv
// Top level: charlieplexed LED PWM scanner with duty store, scan counters and pin masks.
// Results: a tick or force-off item shows its result in the cycle after it is accepted.
// Throughput: one item per cycle; set items update the duty store and give no result.
// The result register frees in the cycle it is taken, so input stalls only on output stall.
// Reset: duty store, PWM step and scan index clear to zero, last state marks none,
// gamma enable resets to 1.
`default_nettype none

module charlieplex_led_pwm_scanner
    import clps_pkg::*;
#(
    parameter int PWM_STEPS  = PWM_STEPS_DEF,
    parameter int GAMMA_X100 = GAMMA_X100_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    clps_cfg_if.sink    cfg,
    clps_in_if.sink     item_in,
    clps_out_if.source  result_out
);

    localparam int DUTY_W = $clog2(PWM_STEPS + 1);
    localparam int STEP_W = $clog2(PWM_STEPS);

    logic                  gamma_enable_reg;
    logic [DUTY_W-1:0]     duty_reg [0:LED_COUNT-1];
    logic [STEP_W-1:0]     pwm_step_reg;
    logic [STEP_W-1:0]     pwm_step_next;
    logic [STATE_W-1:0]    scan_index_reg;
    logic [STATE_W-1:0]    scan_index_next;
    logic [STATE_W-1:0]    last_applied_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATE_W-1:0]    shown_state_reg;
    logic [PIN_COUNT-1:0]  open_drain_reg;
    logic [PIN_COUNT-1:0]  pin_level_reg;
    logic                  changed_reg;

    logic                  accept;
    logic                  is_set;
    logic                  gives_result;
    logic [DUTY_W-1:0]     clamped;
    logic [DUTY_W-1:0]     gamma_duty;
    logic [DUTY_W-1:0]     store_value;
    logic                  lit;
    logic [STATE_W-1:0]    state_new;
    logic [PIN_COUNT-1:0]  anode_bit;
    logic [PIN_COUNT-1:0]  cathode_bit;
    logic [PIN_COUNT-1:0]  od_new;
    logic [PIN_COUNT-1:0]  lv_new;
    logic                  changed_new;

    // Handshake: take a new item whenever the result slot is free or draining
    assign cfg.ready     = 1'b1;
    assign item_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = item_in.valid && item_in.ready;
    assign is_set        = (item_in.opcode == OP_SET_ONE) || (item_in.opcode == OP_SET_ALL);
    assign gives_result  = accept && !is_set;

    // Clamp brightness and select linear or gamma duty
    assign clamped = (item_in.level > LEVEL_W'(PWM_STEPS)) ? DUTY_W'(PWM_STEPS)
                                                          : DUTY_W'(item_in.level);

    clps_gamma_rom #(
        .PWM_STEPS  (PWM_STEPS),
        .GAMMA_X100 (GAMMA_X100),
        .DUTY_W     (DUTY_W)
    ) u_gamma (
        .brightness (clamped),
        .duty       (gamma_duty)
    );

    assign store_value = gamma_enable_reg ? gamma_duty : clamped;

    // Compare the visited LED against the PWM step
    assign lit = duty_reg[scan_index_reg] > DUTY_W'(pwm_step_reg);

    always_comb
    begin
        state_new = HIZ_STATE;
        if (item_in.opcode == OP_TICK && lit)
            state_new = scan_index_reg;
    end

    // Advance scan index, and PWM step on wrap
    always_comb
    begin
        scan_index_next = scan_index_reg;
        pwm_step_next   = pwm_step_reg;
        if (accept && item_in.opcode == OP_TICK) begin
            if (scan_index_reg == STATE_W'(LED_COUNT - 1)) begin
                scan_index_next = '0;
                if (pwm_step_reg == STEP_W'(PWM_STEPS - 1))
                    pwm_step_next = '0;
                else
                    pwm_step_next = pwm_step_reg + STEP_W'(1);
            end
            else begin
                scan_index_next = scan_index_reg + STATE_W'(1);
            end
        end
    end

    // Build pin masks for the new state
    always_comb
    begin
        anode_bit   = PIN_COUNT'(1) << led_anode(state_new);
        cathode_bit = PIN_COUNT'(1) << led_cathode(state_new);
        if (state_new == HIZ_STATE) begin
            od_new = PIN_ALL;
            lv_new = PIN_ALL;
        end
        else begin
            od_new = PIN_ALL & ~(anode_bit | cathode_bit);
            lv_new = PIN_ALL & ~cathode_bit;
        end
    end

    assign changed_new = (state_new != last_applied_reg);

    // Hold result valid until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (gives_result)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gamma_enable_reg <= 1'b1;
            pwm_step_reg     <= '0;
            scan_index_reg   <= '0;
            last_applied_reg <= LAST_NONE;
            out_valid_reg    <= 1'b0;
        end
        else begin
            if (cfg.valid)
                gamma_enable_reg <= cfg.data;
            pwm_step_reg   <= pwm_step_next;
            scan_index_reg <= scan_index_next;
            out_valid_reg  <= out_valid_next;
            if (gives_result && changed_new)
                last_applied_reg <= state_new;
        end
    end

    // Duty store: write one LED or all LEDs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < LED_COUNT; i++)
                duty_reg[i] <= '0;
        end
        else if (accept) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                if (item_in.opcode == OP_SET_ALL ||
                    (item_in.opcode == OP_SET_ONE && item_in.led_number == LED_W'(i)))
                    duty_reg[i] <= store_value;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (gives_result) begin
            shown_state_reg <= state_new;
            open_drain_reg  <= od_new;
            pin_level_reg   <= lv_new;
            changed_reg     <= changed_new;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.shown_state     = shown_state_reg;
    assign result_out.open_drain_mask = open_drain_reg;
    assign result_out.pin_level_mask  = pin_level_reg;
    assign result_out.changed         = changed_reg;

endmodule

`default_nettype wire
